@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sgef_pkg.sv @@
// ----------------------------------------------------------------------------
// sgef_pkg
// Shared types and constants of the Sobel edge filter.
// ----------------------------------------------------------------------------
package sgef_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int THR_W  = 11;
  localparam int WID_W  = 12;
  localparam int HGT_W  = 13;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int RAD_W  = 16;
  localparam int ROOT_W = 8;
  localparam int REM_W  = 9;

  localparam int MIN_SIZE = 3;

  localparam logic [THR_W-1:0] RST_THRESHOLD = THR_W'(0);
  localparam logic [WID_W-1:0] RST_WIDTH     = WID_W'(640);
  localparam logic [HGT_W-1:0] RST_HEIGHT    = HGT_W'(480);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  // Position tag carried alongside each window's gradients.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pos_tag_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    pos_tag_t                 tag;
  } grad_item_t;

endpackage

@@ src/sgef_queue.sv @@
// ----------------------------------------------------------------------------
// sgef_queue
// Short register queue of gradient items between front and back.
// ----------------------------------------------------------------------------
module sgef_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  sgef_pkg::grad_item_t   push_item,
  output logic                   pop_valid,
  input  logic                   pop,
  output sgef_pkg::grad_item_t   pop_item
);
  import sgef_pkg::*;

  grad_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/sgef_front.sv @@
// ----------------------------------------------------------------------------
// sgef_front
// Pixel intake: raster counters, line memory, 3x3 window and Sobel sums.
// ----------------------------------------------------------------------------
module sgef_front #(
  parameter int MAX_WIDTH  = sgef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgef_pkg::DEF_MAX_HEIGHT,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT),
  parameter int CW1        = $clog2(MAX_WIDTH + 1),
  parameter int RW1        = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [CW1-1:0]             width_use,
  input  logic [RW1-1:0]             height_use,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sgef_pkg::PIX_W-1:0] gray,
  output logic                       push_valid,
  input  logic                       push_ready,
  output sgef_pkg::grad_item_t       push_item
);
  import sgef_pkg::*;

  // Line memory entry: {two rows above, one row above}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd;

  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [CW-1:0]      col_next;
  logic [RW-1:0]      row_next;
  logic               at_col_end;
  logic               at_row_end;
  logic               accept;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pixel;
  logic [CW-1:0]      s1_col;
  logic [RW-1:0]      s1_row;
  logic               s1_last;
  logic               s1_produce;
  logic               s1_go;

  logic [PIX_W-1:0]   win [6];
  logic [PIX_W-1:0]   top_pix;
  logic [PIX_W-1:0]   mid_pix;
  logic [GRAD_W-1:0]  sum_a;
  logic [GRAD_W-1:0]  sum_b;
  logic [GRAD_W-1:0]  sum_c;
  logic [GRAD_W-1:0]  sum_d;

  assign at_col_end = (CW1'(col) + CW1'(1)) >= width_use;
  assign at_row_end = (RW1'(row) + RW1'(1)) >= height_use;
  assign accept     = in_valid && in_ready;

  always_comb begin
    col_next = col + CW'(1);
    row_next = row;
    if (at_col_end) begin
      col_next = '0;
      row_next = at_row_end ? '0 : row + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Read at intake, write back once the window stage moves on
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col];
    end
    if (s1_go) begin
      line_mem[s1_col] <= {mid_pix, s1_pixel};
    end
  end

  assign top_pix    = line_rd[2*PIX_W-1:PIX_W];
  assign mid_pix    = line_rd[PIX_W-1:0];
  assign s1_produce = (s1_row >= RW'(2)) && (s1_col >= CW'(2));
  assign s1_go      = s1_valid && (!s1_produce || push_ready);
  assign in_ready   = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= gray;
      s1_col   <= col;
      s1_row   <= row;
      s1_last  <= at_col_end && at_row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_go) begin
      win[0] <= win[1];
      win[1] <= top_pix;
      win[2] <= win[3];
      win[3] <= mid_pix;
      win[4] <= win[5];
      win[5] <= s1_pixel;
    end
  end

  // Right minus left column, bottom minus top row; each weighted sum stays positive
  assign sum_a = GRAD_W'(top_pix) + GRAD_W'({mid_pix, 1'b0}) + GRAD_W'(s1_pixel);
  assign sum_b = GRAD_W'(win[0]) + GRAD_W'({win[2], 1'b0}) + GRAD_W'(win[4]);
  assign sum_c = GRAD_W'(win[4]) + GRAD_W'({win[5], 1'b0}) + GRAD_W'(s1_pixel);
  assign sum_d = GRAD_W'(win[0]) + GRAD_W'({win[1], 1'b0}) + GRAD_W'(top_pix);

  assign push_valid    = s1_valid && s1_produce;
  assign push_item.gx  = $signed(sum_a) - $signed(sum_b);
  assign push_item.gy  = $signed(sum_c) - $signed(sum_d);
  assign push_item.tag.row  = ROW_W'(s1_row - RW'(2));
  assign push_item.tag.col  = COL_W'(s1_col - CW'(2));
  assign push_item.tag.last = s1_last;

endmodule

@@ src/sgef_back.sv @@
// ----------------------------------------------------------------------------
// sgef_back
// Gradient magnitude: squares, sum, pipelined bit-pair square root, floor
// and saturation, output register.
// ----------------------------------------------------------------------------
module sgef_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sgef_pkg::THR_W-1:0]  threshold,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  sgef_pkg::grad_item_t        q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sgef_pkg::PIX_W-1:0]  edge_value,
  output logic [sgef_pkg::ROW_W-1:0]  out_row,
  output logic [sgef_pkg::COL_W-1:0]  out_col,
  output logic                        frame_last
);
  import sgef_pkg::*;

  localparam int NSTEP = ROOT_W;

  logic                     en;
  logic signed [2*GRAD_W-1:0] prod_x;
  logic signed [2*GRAD_W-1:0] prod_y;

  logic                     sq_valid;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  pos_tag_t                 sq_tag;
  logic [SQ_W:0]            sq_sum;

  logic                     st_valid [NSTEP+1];
  logic [RAD_W-1:0]         st_rad   [NSTEP+1];
  logic                     st_big   [NSTEP+1];
  pos_tag_t                 st_tag   [NSTEP+1];
  logic [REM_W-1:0]         st_rem   [NSTEP+1];
  logic [ROOT_W-1:0]        st_root  [NSTEP+1];

  logic [PIX_W-1:0]         val_next;

  // Whole pipeline moves together whenever the output register can take an item
  assign en     = !out_valid || out_ready;
  assign q_pop  = en && q_valid;
  assign prod_x = q_item.gx * q_item.gx;
  assign prod_y = q_item.gy * q_item.gy;
  assign sq_sum = (SQ_W+1)'(sq_x) + (SQ_W+1)'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x   <= prod_x[SQ_W-1:0];
      sq_y   <= prod_y[SQ_W-1:0];
      sq_tag <= q_item.tag;
    end
  end

  // A sum of 2^16 or more has a root above 255: only the saturation flag matters
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (en) begin
      st_valid[0] <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rad[0]  <= sq_sum[RAD_W-1:0];
      st_big[0]  <= (sq_sum[SQ_W:RAD_W] != '0);
      st_tag[0]  <= sq_tag;
      st_rem[0]  <= '0;
      st_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_root
    logic [REM_W+1:0]  rem_ext;
    logic [REM_W+1:0]  trial;
    logic              fits;

    // Bring in the next two radicand bits, most significant pair first
    assign rem_ext = {st_rem[j], st_rad[j][RAD_W-1-2*j -: 2]};
    assign trial   = (REM_W+2)'({st_root[j], 2'b01});
    assign fits    = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[j+1] <= 1'b0;
      end else if (en) begin
        st_valid[j+1] <= st_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rad[j+1]  <= st_rad[j];
        st_big[j+1]  <= st_big[j];
        st_tag[j+1]  <= st_tag[j];
        st_rem[j+1]  <= fits ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
        st_root[j+1] <= {st_root[j][ROOT_W-2:0], fits};
      end
    end
  end

  always_comb begin
    if (st_big[NSTEP] || (threshold > THR_W'(255))) begin
      val_next = '1;
    end else if (THR_W'(st_root[NSTEP]) > threshold) begin
      val_next = st_root[NSTEP];
    end else begin
      val_next = threshold[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edge_value <= val_next;
      out_row    <= st_tag[NSTEP].row;
      out_col    <= st_tag[NSTEP].col;
      frame_last <= st_tag[NSTEP].last;
    end
  end

endmodule

@@ src/sobel_gradient_edge_filter_core.sv @@
// ----------------------------------------------------------------------------
// sobel_gradient_edge_filter_core
// 3x3 Sobel edge filter on a raster stream of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained, for as long as results are taken;
// the single read port of the line memory and the one-pixel window stage
// set that figure. A result passes from the pixel that completes its
// window through the window stage, queue, squares, sum, eight root
// steps and output register. Border pixels give no result. The line memory
// needs no clearing pass: the first two rows of every frame fill it before
// it is read. Writing the width or height restarts the frame at row 0,
// column 0; sizes are clamped to 3 .. MAX_WIDTH and 3 .. MAX_HEIGHT.
// Registers: 0x0 threshold, 0x4 width, 0x8 height.
module sobel_gradient_edge_filter_core #(
  parameter int MAX_WIDTH  = sgef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgef_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sgef_pkg::PIX_W-1:0] gray,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sgef_pkg::PIX_W-1:0] edge_value,
  output logic [sgef_pkg::ROW_W-1:0] out_row,
  output logic [sgef_pkg::COL_W-1:0] out_col,
  output logic                       frame_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sgef_pkg::*;

  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int RW1 = $clog2(MAX_HEIGHT + 1);

  logic [THR_W-1:0] threshold;
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic             wr_en;
  reg_idx_t         reg_idx;
  logic             restart;
  logic [CW1-1:0]   width_use;
  logic [RW1-1:0]   height_use;

  logic             push_valid;
  logic             push_ready;
  grad_item_t       push_item;
  logic             q_valid;
  logic             q_pop;
  grad_item_t       q_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign restart = wr_en && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= RST_THRESHOLD;
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD: threshold    <= pwdata[THR_W-1:0];
        REG_WIDTH:     image_width  <= pwdata[WID_W-1:0];
        REG_HEIGHT:    image_height <= pwdata[HGT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = 32'(threshold);
      REG_WIDTH:     prdata = 32'(image_width);
      REG_HEIGHT:    prdata = 32'(image_height);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    priority if (image_width < WID_W'(MIN_SIZE)) begin
      width_use = CW1'(MIN_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_use = CW1'(MAX_WIDTH);
    end else begin
      width_use = CW1'(image_width);
    end
  end

  always_comb begin
    priority if (image_height < HGT_W'(MIN_SIZE)) begin
      height_use = RW1'(MIN_SIZE);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height_use = RW1'(MAX_HEIGHT);
    end else begin
      height_use = RW1'(image_height);
    end
  end

  sgef_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .width_use  (width_use),
    .height_use (height_use),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .gray       (gray),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sgef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  sgef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .threshold  (threshold),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_value (edge_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

endmodule

@@ src/sgef_checker.sv @@
// ----------------------------------------------------------------------------
// sgef_checker
// Port-level checks on the edge filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgef_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  edge_value,
  input logic [11:0] out_row,
  input logic [10:0] out_col,
  input logic        frame_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready
);

  // A result waiting on the output holds all its fields
  `ASSERT_CLKD(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(edge_value) && $stable(out_row) && $stable(out_col) && $stable(frame_last)), "stalled result changed")

  // Reset empties the pipeline
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result present after reset")

  // Window origin never reaches the last two rows or columns
  `ASSERT_CLKD(a_pos_range, clk, rst, out_valid |-> ((out_row <= 12'd4093) && (out_col <= 11'd2045)), "window origin out of range")

  // Register port never inserts wait states
  `ASSERT_CLKD(a_no_wait, clk, rst, (psel && penable) |-> pready, "register access stalled")

endmodule

bind sobel_gradient_edge_filter_core sgef_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .edge_value (edge_value),
  .out_row    (out_row),
  .out_col    (out_col),
  .frame_last (frame_last),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .pready     (pready)
);
